FILE: hdl/pcac_pkg.sv
package pcac_pkg;

    // Register reset values
    localparam logic [15:0] MS_DIVISOR_RST    = 16'd30;
    localparam logic [15:0] SLOW_DIVISOR_RST  = 16'd3000;
    localparam logic [12:0] BLINK_UNIT_RST    = 13'd200;
    localparam logic [15:0] PUMP_ON_TIME_RST  = 16'd10;
    localparam logic [15:0] PAUSE_TIME_RST    = 16'd300;
    localparam logic [15:0] ESCALATE_TIME_RST = 16'd1200;
    localparam logic [1:0]  BOARD_VARIANT_RST = 2'd0;

    // Highest slot multiple of the blink unit that the patterns use
    localparam int BLINK_SLOTS = 10;

    // Register index on the APB port (byte address divided by four)
    typedef enum logic [2:0] {
        REG_MS_DIVISOR    = 3'd0,
        REG_SLOW_DIVISOR  = 3'd1,
        REG_BLINK_UNIT    = 3'd2,
        REG_PUMP_ON_TIME  = 3'd3,
        REG_PAUSE_TIME    = 3'd4,
        REG_ESCALATE_TIME = 3'd5,
        REG_BOARD_VARIANT = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        SP_IDLE  = 3'd0,
        SP_PUMP  = 3'd1,
        SP_CHECK = 3'd2,
        SP_PAUSE = 3'd3,
        SP_FAULT = 3'd4
    } step_t;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_PUMPING = 2'd1,
        ST_FAULT   = 2'd2,
        ST_ESCAL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BV_SMALL    = 2'd0,
        BV_LARGE    = 2'd1,
        BV_LARGE_V2 = 2'd2
    } variant_t;

    // Configuration as seen by the sequencer core
    typedef struct packed {
        logic [15:0]                       ms_divisor;
        logic [15:0]                       slow_divisor;
        logic [15:0]                       pump_on_time;
        logic [15:0]                       pause_time;
        logic [15:0]                       escalate_time;
        logic [1:0]                        board_variant;
        logic [15:0]                       toggle_limit;
        logic [BLINK_SLOTS:0][16:0]        blink_mult;
    } cfg_t;

    // One input beat
    typedef struct packed {
        logic reset_button;
        logic pressure_detect;
        logic remote_reset;
    } tick_t;

    // One result beat
    typedef struct packed {
        logic       pump_on;
        logic       red_lamp;
        logic       green_lamp;
        logic       buzzer_on;
        logic       indicator_lamp;
        logic [1:0] status_code;
        logic [2:0] step_code;
        logic       remote_reset_taken;
    } result_t;

endpackage

FILE: hdl/pcac_tick_if.sv
interface pcac_tick_if;
    logic valid;
    logic ready;
    logic reset_button;
    logic pressure_detect;
    logic remote_reset;

    modport source (
        output valid,
        input  ready,
        output reset_button,
        output pressure_detect,
        output remote_reset
    );

    modport sink (
        input  valid,
        output ready,
        input  reset_button,
        input  pressure_detect,
        input  remote_reset
    );
endinterface

FILE: hdl/pcac_result_if.sv
interface pcac_result_if;
    logic       valid;
    logic       ready;
    logic       pump_on;
    logic       red_lamp;
    logic       green_lamp;
    logic       buzzer_on;
    logic       indicator_lamp;
    logic [1:0] status_code;
    logic [2:0] step_code;
    logic       remote_reset_taken;

    modport source (
        output valid,
        input  ready,
        output pump_on,
        output red_lamp,
        output green_lamp,
        output buzzer_on,
        output indicator_lamp,
        output status_code,
        output step_code,
        output remote_reset_taken
    );

    modport sink (
        input  valid,
        output ready,
        input  pump_on,
        input  red_lamp,
        input  green_lamp,
        input  buzzer_on,
        input  indicator_lamp,
        input  status_code,
        input  step_code,
        input  remote_reset_taken
    );
endinterface

FILE: hdl/pcac_cfg.sv
module pcac_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output pcac_pkg::cfg_t  cfg
);
    import pcac_pkg::*;

    logic [15:0] ms_divisor_reg;
    logic [15:0] slow_divisor_reg;
    logic [12:0] blink_unit_reg;
    logic [15:0] pump_on_time_reg;
    logic [15:0] pause_time_reg;
    logic [15:0] escalate_time_reg;
    logic [1:0]  board_variant_reg;
    logic [15:0] toggle_limit_reg;
    logic [15:0] toggle_limit_next;
    logic [BLINK_SLOTS:0][16:0] blink_mult_reg;
    logic [BLINK_SLOTS:0][16:0] blink_mult_next;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    // Write the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_divisor_reg    <= MS_DIVISOR_RST;
            slow_divisor_reg  <= SLOW_DIVISOR_RST;
            blink_unit_reg    <= BLINK_UNIT_RST;
            pump_on_time_reg  <= PUMP_ON_TIME_RST;
            pause_time_reg    <= PAUSE_TIME_RST;
            escalate_time_reg <= ESCALATE_TIME_RST;
            board_variant_reg <= BOARD_VARIANT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MS_DIVISOR:    ms_divisor_reg    <= pwdata[15:0];
                REG_SLOW_DIVISOR:  slow_divisor_reg  <= pwdata[15:0];
                REG_BLINK_UNIT:    blink_unit_reg    <= pwdata[12:0];
                REG_PUMP_ON_TIME:  pump_on_time_reg  <= pwdata[15:0];
                REG_PAUSE_TIME:    pause_time_reg    <= pwdata[15:0];
                REG_ESCALATE_TIME: escalate_time_reg <= pwdata[15:0];
                REG_BOARD_VARIANT: board_variant_reg <= pwdata[1:0];
                default:           ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_MS_DIVISOR:    prdata = {16'd0, ms_divisor_reg};
            REG_SLOW_DIVISOR:  prdata = {16'd0, slow_divisor_reg};
            REG_BLINK_UNIT:    prdata = {19'd0, blink_unit_reg};
            REG_PUMP_ON_TIME:  prdata = {16'd0, pump_on_time_reg};
            REG_PAUSE_TIME:    prdata = {16'd0, pause_time_reg};
            REG_ESCALATE_TIME: prdata = {16'd0, escalate_time_reg};
            REG_BOARD_VARIANT: prdata = {30'd0, board_variant_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Derive slot edges and the toggle limit from the blink unit
    always_comb
    begin
        toggle_limit_next = 16'({4'd0, blink_unit_reg[12:1]} * 16'd5);
        for (int k = 0; k <= BLINK_SLOTS; k++)
        begin
            blink_mult_next[k] = {4'd0, blink_unit_reg} * 17'(k);
        end
    end

    // Hold the derived values in registers so the core sees short paths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_limit_reg <= 16'({4'd0, BLINK_UNIT_RST[12:1]} * 16'd5);
            for (int k = 0; k <= BLINK_SLOTS; k++)
            begin
                blink_mult_reg[k] <= {4'd0, BLINK_UNIT_RST} * 17'(k);
            end
        end
        else
        begin
            toggle_limit_reg <= toggle_limit_next;
            blink_mult_reg   <= blink_mult_next;
        end
    end

    assign cfg.ms_divisor    = ms_divisor_reg;
    assign cfg.slow_divisor  = slow_divisor_reg;
    assign cfg.pump_on_time  = pump_on_time_reg;
    assign cfg.pause_time    = pause_time_reg;
    assign cfg.escalate_time = escalate_time_reg;
    assign cfg.board_variant = board_variant_reg;
    assign cfg.toggle_limit  = toggle_limit_reg;
    assign cfg.blink_mult    = blink_mult_reg;

endmodule

FILE: hdl/pcac_core.sv
module pcac_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  pcac_pkg::cfg_t    cfg,
    input  pcac_pkg::tick_t   tick,
    output pcac_pkg::result_t res
);
    import pcac_pkg::*;

    logic [15:0]      ms_prescale_reg,   ms_prescale_next;
    logic [15:0]      slow_prescale_reg, slow_prescale_next;
    logic [15:0]      phase_timer_reg,   phase_timer_next;
    logic [15:0]      toggle_timer_reg,  toggle_timer_next;
    logic [2:0][15:0] pattern_timer_reg, pattern_timer_next;
    logic [3:0]       blink_reg,         blink_next;
    step_t            step_reg,          step_next;
    status_t          status_reg,        status_next;
    logic             pump_reg,          pump_next;

    logic       ms_tick;
    logic       slow_tick;
    logic [2:0] last_slot [3];
    logic       red;
    logic       green;
    logic       buzz;
    logic       ind;

    assign last_slot[0] = 3'd3;
    assign last_slot[1] = 3'd5;
    assign last_slot[2] = 3'd7;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Level of a multi-pulse pattern: high below one unit, alternating in the
    // slots after it, held on slot edges and past the last slot
    function automatic logic pat_level(
        input logic [15:0]                 t,
        input logic [BLINK_SLOTS:0][16:0]  m,
        input logic [2:0]                  last_k,
        input logic                        hold
    );
        logic        lv;
        logic [16:0] tw;
        lv = hold;
        tw = {1'b0, t};
        if (tw < m[1])
        begin
            lv = 1'b1;
        end
        else
        begin
            for (int k = 1; k < 8; k++)
            begin
                if ((3'(k) <= last_k) && (tw > m[k]) && (tw < m[k + 1]))
                begin
                    lv = (k[0] == 1'b0);
                end
            end
        end
        return lv;
    endfunction

    // Advance prescalers, timers and blink patterns
    always_comb
    begin
        ms_prescale_next   = ms_prescale_reg + 16'd1;
        slow_prescale_next = slow_prescale_reg + 16'd1;
        toggle_timer_next  = toggle_timer_reg;
        pattern_timer_next = pattern_timer_reg;
        phase_timer_next   = phase_timer_reg;
        blink_next         = blink_reg;

        ms_tick = (ms_prescale_next >= cfg.ms_divisor);
        if (ms_tick)
        begin
            ms_prescale_next  = 16'd0;
            toggle_timer_next = sat_inc(toggle_timer_reg);
            for (int p = 0; p < 3; p++)
            begin
                pattern_timer_next[p] = sat_inc(pattern_timer_reg[p]);
            end
        end

        slow_tick = (slow_prescale_next >= cfg.slow_divisor);
        if (slow_tick)
        begin
            slow_prescale_next = 16'd0;
            phase_timer_next   = sat_inc(phase_timer_reg);
        end

        if (toggle_timer_next > cfg.toggle_limit)
        begin
            blink_next[0]     = ~blink_reg[0];
            toggle_timer_next = 16'd0;
        end

        for (int p = 0; p < 3; p++)
        begin
            blink_next[p + 1] = pat_level(pattern_timer_next[p], cfg.blink_mult,
                                          last_slot[p], blink_reg[p + 1]);
            if ({1'b0, pattern_timer_next[p]} > cfg.blink_mult[BLINK_SLOTS])
            begin
                pattern_timer_next[p] = 16'd0;
            end
        end

        // Apply reset and pressure overrides, then run one sequencer step
        step_next   = step_reg;
        status_next = status_reg;
        pump_next   = pump_reg;
        if (tick.reset_button || tick.remote_reset)
        begin
            step_next   = SP_IDLE;
            pump_next   = 1'b0;
            status_next = ST_NORMAL;
        end
        if (tick.pressure_detect)
        begin
            status_next = ST_FAULT;
            step_next   = SP_FAULT;
            pump_next   = 1'b0;
        end
        case (step_next)
            SP_IDLE:
            begin
                if (!tick.pressure_detect)
                begin
                    step_next        = SP_PUMP;
                    phase_timer_next = 16'd0;
                end
                else
                begin
                    status_next = ST_FAULT;
                    step_next   = SP_FAULT;
                end
            end
            SP_PUMP:
            begin
                status_next = ST_PUMPING;
                pump_next   = 1'b1;
                if (phase_timer_next > cfg.pump_on_time)
                begin
                    step_next        = SP_CHECK;
                    phase_timer_next = 16'd0;
                    pump_next        = 1'b0;
                    status_next      = ST_NORMAL;
                end
            end
            SP_CHECK:
            begin
                if (tick.pressure_detect)
                begin
                    step_next   = SP_FAULT;
                    status_next = ST_FAULT;
                end
                else
                begin
                    step_next   = SP_PAUSE;
                    status_next = ST_NORMAL;
                end
            end
            SP_PAUSE:
            begin
                if (phase_timer_next > cfg.pause_time)
                begin
                    step_next        = SP_PUMP;
                    phase_timer_next = 16'd0;
                end
            end
            SP_FAULT:
            begin
                if (phase_timer_next > cfg.escalate_time)
                begin
                    status_next = ST_ESCAL;
                end
            end
            default: ;
        endcase
    end

    // Decode lamp and buzzer levels for the board variant
    always_comb
    begin
        if (variant_t'(cfg.board_variant) == BV_SMALL)
        begin
            case (status_next)
                ST_FAULT:
                begin
                    red = blink_next[0]; green = 1'b0; buzz = 1'b1; ind = blink_next[2];
                end
                ST_PUMPING:
                begin
                    red = 1'b1; green = 1'b1; buzz = 1'b0; ind = blink_next[1];
                end
                ST_ESCAL:
                begin
                    red = blink_next[0]; green = 1'b0; buzz = 1'b1; ind = blink_next[3];
                end
                default:
                begin
                    red = 1'b0; green = 1'b1; buzz = 1'b0; ind = blink_next[0];
                end
            endcase
        end
        else
        begin
            case (status_next)
                ST_FAULT:
                begin
                    red   = blink_next[0];
                    green = 1'b1;
                    buzz  = (variant_t'(cfg.board_variant) == BV_LARGE) ? 1'b0 : 1'b1;
                    ind   = blink_next[2];
                end
                ST_PUMPING:
                begin
                    red = 1'b0; green = 1'b0; buzz = 1'b0; ind = blink_next[1];
                end
                ST_ESCAL:
                begin
                    red = blink_next[0]; green = 1'b1; buzz = 1'b1; ind = blink_next[3];
                end
                default:
                begin
                    red = 1'b0; green = 1'b0; buzz = 1'b0; ind = blink_next[0];
                end
            endcase
        end
    end

    assign res.pump_on            = pump_next;
    assign res.red_lamp           = red;
    assign res.green_lamp         = green;
    assign res.buzzer_on          = buzz;
    assign res.indicator_lamp     = ind;
    assign res.status_code        = status_next;
    assign res.step_code          = step_next;
    assign res.remote_reset_taken = tick.remote_reset;

    // Commit state once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_prescale_reg   <= 16'd0;
            slow_prescale_reg <= 16'd0;
            phase_timer_reg   <= 16'd0;
            toggle_timer_reg  <= 16'd0;
            pattern_timer_reg <= '0;
            blink_reg         <= 4'd0;
            step_reg          <= SP_IDLE;
            status_reg        <= ST_NORMAL;
            pump_reg          <= 1'b0;
        end
        else if (en)
        begin
            ms_prescale_reg   <= ms_prescale_next;
            slow_prescale_reg <= slow_prescale_next;
            phase_timer_reg   <= phase_timer_next;
            toggle_timer_reg  <= toggle_timer_next;
            pattern_timer_reg <= pattern_timer_next;
            blink_reg         <= blink_next;
            step_reg          <= step_next;
            status_reg        <= status_next;
            pump_reg          <= pump_next;
        end
    end

    // The pump runs only in the pumping step
    a_pump_step: assert property (@(posedge clk) disable iff (!rst_n)
        pump_reg |-> (step_reg == SP_PUMP))
        else $error("pump driven outside the pumping step");

    // Escalated status only comes out of the fault step
    a_escal_step: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == ST_ESCAL) |-> (step_reg == SP_FAULT))
        else $error("escalated status outside the fault step");

    // Pressure on a committed beat always lands in fault
    a_pressure_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (en && tick.pressure_detect) |=> (step_reg == SP_FAULT) && !pump_reg)
        else $error("pressure beat did not force fault");

    // A reset beat without pressure restarts the pumping step at once
    a_reset_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (en && (tick.reset_button || tick.remote_reset) && !tick.pressure_detect)
        |=> (step_reg == SP_PUMP) && (phase_timer_reg == 16'd0))
        else $error("reset beat did not restart the pump cycle");

endmodule

FILE: hdl/pump_cycle_alarm_controller_core.sv
// A tick beat goes through the input register, then the result register, to its result beat.
// Throughput: one tick beat per cycle unless the result register stalls; the state update
// is a single registered pass.
// The input register lets a new beat in while the result waits, ready drops only on stall.
// Reset (rst_n, asynchronous, active low) clears all timers, the blink levels, the
// sequencer to idle/normal/pump off, and loads the default register values.
module pump_cycle_alarm_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pcac_tick_if.sink     ticks,
    pcac_result_if.source results
);
    import pcac_pkg::*;

    cfg_t    cfg;
    tick_t   tick_data_reg;
    logic    tick_valid_reg;
    result_t core_res;
    result_t res_data_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    take;

    pcac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held beat forward whenever the result slot is free or draining
    assign advance     = !res_valid_reg || results.ready;
    assign ticks.ready = !tick_valid_reg || advance;
    assign take        = ticks.valid && ticks.ready;

    pcac_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (tick_valid_reg && advance),
        .cfg   (cfg),
        .tick  (tick_data_reg),
        .res   (core_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            tick_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            tick_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tick_data_reg.reset_button    <= ticks.reset_button;
            tick_data_reg.pressure_detect <= ticks.pressure_detect;
            tick_data_reg.remote_reset    <= ticks.remote_reset;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= tick_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid_reg && advance)
        begin
            res_data_reg <= core_res;
        end
    end

    assign results.valid              = res_valid_reg;
    assign results.pump_on            = res_data_reg.pump_on;
    assign results.red_lamp           = res_data_reg.red_lamp;
    assign results.green_lamp         = res_data_reg.green_lamp;
    assign results.buzzer_on          = res_data_reg.buzzer_on;
    assign results.indicator_lamp     = res_data_reg.indicator_lamp;
    assign results.status_code        = res_data_reg.status_code;
    assign results.step_code          = res_data_reg.step_code;
    assign results.remote_reset_taken = res_data_reg.remote_reset_taken;

endmodule
